// ===== rtl/stmf_pkg.sv =====
// Shared constants and types for the sliding trimmed mean filter.
// No dependencies; used by the cell, divider, top level and bench.
`default_nettype none
package stmf_pkg;

  localparam int unsigned WINDOW  = 16;
  localparam int unsigned TRIM    = WINDOW / 4;
  localparam int unsigned HALF    = 2 * TRIM;
  localparam int unsigned SMP_W   = 12;
  localparam int unsigned AGE_W   = $clog2(WINDOW);
  localparam int unsigned AGE_MAX = WINDOW - 1;
  localparam int unsigned SUM_W   = $clog2(HALF * (2 ** SMP_W));
  localparam int unsigned CNT_W   = $clog2(HALF);

  // Reciprocal of HALF scaled by 2**DIV_SH, rounded up.
  localparam int unsigned DIV_SH  = SUM_W + $clog2(HALF);
  localparam int unsigned RCP_W   = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = RCP_W'((2 ** DIV_SH + HALF - 1) / HALF);

  typedef logic [SMP_W-1:0] smp_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Raw contents of a cell, passed down to its lower neighbor.
  typedef struct packed {
    smp_t val;
    age_t age;
  } down_t;

  // Post-eviction view of a cell, passed up to its upper neighbor.
  typedef struct packed {
    smp_t cval;
    age_t cage;
    logic le;
    logic below;
  } up_t;

endpackage
`default_nettype wire

// ===== rtl/stmf_cell.sv =====
// One cell of the sorted window chain plus its readout shadow register.
// Depends on stmf_pkg.
`default_nettype none
module stmf_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire stmf_pkg::age_t  idx_i,
  input  wire stmf_pkg::smp_t  smp_i,
  input  wire logic            ins_i,
  input  wire logic            load_i,
  input  wire logic            shift_i,
  input  wire stmf_pkg::up_t   lo_i,
  input  wire stmf_pkg::down_t hi_i,
  input  wire stmf_pkg::smp_t  sh_hi_i,
  output stmf_pkg::up_t        up_o,
  output stmf_pkg::down_t      dn_o,
  output stmf_pkg::smp_t       sh_o
);

  stmf_pkg::smp_t val_q, val_d, sh_q, cval;
  stmf_pkg::age_t age_q, age_d, cage;
  logic           del, below, le;

  // Oldest entry drops out; cells above it close the gap, then the sample slots in.
  assign del   = (age_q == stmf_pkg::AGE_W'(stmf_pkg::AGE_MAX));
  assign below = lo_i.below & ~del;
  assign cval  = below ? val_q : hi_i.val;
  assign cage  = below ? age_q : hi_i.age;
  assign le    = (cval <= smp_i);

  assign up_o = '{cval: cval, cage: cage, le: le, below: below};
  assign dn_o = '{val: val_q, age: age_q};
  assign sh_o = sh_q;

  always_comb begin
    if (le) begin
      val_d = cval;
      age_d = cage + stmf_pkg::AGE_W'(1);
    end else if (lo_i.le) begin
      val_d = smp_i;
      age_d = '0;
    end else begin
      val_d = lo_i.cval;
      age_d = lo_i.cage + stmf_pkg::AGE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= idx_i;
    end else if (ins_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sh_q <= val_q;
    end else if (shift_i) begin
      sh_q <= sh_hi_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stmf_div.sv =====
// Division by the constant HALF as a multiply by its scaled reciprocal.
// Depends on stmf_pkg.
`default_nettype none
module stmf_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire stmf_pkg::sum_t dividend_i,
  output logic                done_o,
  output stmf_pkg::smp_t      quot_o
);

  stmf_pkg::sum_t              dvd_q;
  logic [stmf_pkg::PROD_W-1:0] prod;
  logic                        done_q;

  // Exact floor quotient for every dividend that fits in SUM_W bits.
  assign prod   = stmf_pkg::PROD_W'(dvd_q) * stmf_pkg::PROD_W'(stmf_pkg::RCP);
  assign done_o = done_q;
  assign quot_o = prod[stmf_pkg::DIV_SH +: stmf_pkg::SMP_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_trimmed_mean_filter.sv =====
// Sliding-window interquartile mean of a 12-bit sample stream.
// Depends on stmf_pkg, stmf_cell and stmf_div.
//
// Usage:
//   s_axis: one sample per transfer, tdata[11:0] = sample.
//   m_axis: one result per sample, tdata[11:0] = filtered, upper bits zero.
//   Each sample replaces the oldest of WINDOW entries held in a sorted chain
//   of cells; the insert and the eviction happen in the accepting cycle.
//   The sorted values are then copied into a shadow shift line, the middle
//   half is summed one cell per cycle and the sum is divided by WINDOW/2
//   through a registered multiply by its reciprocal. The states LOAD,
//   SUM, DIV and DONE follow the input transfer in turn before
//   m_axis_tvalid rises; one item is in flight at a time, so no new
//   sample is taken until DONE has loaded the output register.
//   Reset clears the window to zero and empties the output register; until
//   WINDOW samples have arrived the zero entries count as samples.
//   A stalled receiver holds the result in the output register; the next
//   sample is still taken and processed, and the block waits only if a new
//   result is ready while the previous one has not been transferred.
`default_nettype none
module sliding_trimmed_mean_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [11:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [11:0] filtered
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [stmf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  stmf_pkg::sum_t             acc_q, acc_d, dividend;
  stmf_pkg::smp_t             out_q, sample, quot;
  logic                       out_vld_q, out_vld_d, out_load;
  logic                       s_xfer, ins, load, shift, div_start, div_done, sum_last;

  stmf_pkg::up_t   up   [stmf_pkg::WINDOW];
  stmf_pkg::down_t dn   [stmf_pkg::WINDOW];
  stmf_pkg::smp_t  sh   [stmf_pkg::WINDOW];

  assign sample        = s_axis_tdata[stmf_pkg::SMP_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign ins           = s_xfer;
  assign load          = (state_q == ST_LOAD);
  assign shift         = (state_q == ST_SUM);
  assign sum_last      = (cnt_q == stmf_pkg::CNT_W'(stmf_pkg::HALF - 1));
  assign div_start     = shift & sum_last;
  assign dividend      = acc_q + stmf_pkg::SUM_W'(sh[stmf_pkg::TRIM]);

  for (genvar i = 0; i < stmf_pkg::WINDOW; i++) begin : g_cell
    stmf_pkg::up_t   lo;
    stmf_pkg::down_t hi;
    stmf_pkg::smp_t  sh_hi;
    if (i == 0) begin : g_bot
      assign lo = '{cval: '0, cage: '0, le: 1'b1, below: 1'b1};
    end else begin : g_mid
      assign lo = up[i-1];
    end
    if (i == stmf_pkg::WINDOW - 1) begin : g_top
      // Empty slot above the chain: largest value, age wraps to zero on insert.
      assign hi    = '{val: '1, age: '1};
      assign sh_hi = '0;
    end else begin : g_low
      assign hi    = dn[i+1];
      assign sh_hi = sh[i+1];
    end
    stmf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (stmf_pkg::AGE_W'(i)),
      .smp_i   (sample),
      .ins_i   (ins),
      .load_i  (load),
      .shift_i (shift),
      .lo_i    (lo),
      .hi_i    (hi),
      .sh_hi_i (sh_hi),
      .up_o    (up[i]),
      .dn_o    (dn[i]),
      .sh_o    (sh[i])
    );
  end

  stmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    out_load  = 1'b0;
    out_vld_d = out_vld_q & ~m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_d   = '0;
        acc_d   = '0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d = dividend;
        cnt_d = cnt_q + stmf_pkg::CNT_W'(1);
        if (sum_last) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (out_load) out_q <= quot;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q};

endmodule
`default_nettype wire

// ===== rtl/stmf_checker.sv =====
// Port-level assertions for sliding_trimmed_mean_filter, attached by bind.
// Depends only on the top-level ports.
`default_nettype none
module stmf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // One item at a time: an input transfer closes the input side.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // A new result is only ever produced at the end of a work phase.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:12] == 4'b0))
    else $error("tdata padding not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind sliding_trimmed_mean_filter stmf_checker u_stmf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for sliding_trimmed_mean_filter: directed edge samples, then random
// streams with random gaps and receiver stalls; results compared with an in-bench predictor.
// Depends on stmf_pkg and the RTL of sliding_trimmed_mean_filter.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned RANDOM_ITEMS    = 1325;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned DRAIN_CYCLES    = 2 * (stmf_pkg::HALF + 16);
  localparam int unsigned SMP_TOP         = 2 ** stmf_pkg::SMP_W - 1;

  // Upper nibble set on three of the first four words: it must be ignored.
  localparam logic [15:0] DIRECTED [25] = '{
    16'hFFFF, 16'h0000, 16'h5AAA, 16'hA555,
    16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF,
    16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF,
    16'h0001, 16'h0800, 16'h07FF, 16'h0FFE,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  class trimmed_mean_board;
    stmf_pkg::smp_t window_vals[stmf_pkg::WINDOW];
    int unsigned    newest_slot;
    stmf_pkg::smp_t expected_means[$];
    int unsigned    errors;

    function new();
      foreach (window_vals[i]) window_vals[i] = '0;
      newest_slot = 0;
      errors      = 0;
    endfunction

    // Insert the accepted sample and queue the mean of the middle half.
    function void note_sample(stmf_pkg::smp_t sample);
      stmf_pkg::smp_t ordered[stmf_pkg::WINDOW];
      stmf_pkg::smp_t key;
      int             j;
      int unsigned    total;
      int unsigned    mean;
      newest_slot = (newest_slot + 1 >= stmf_pkg::WINDOW) ? 0 : newest_slot + 1;
      window_vals[newest_slot] = sample;
      ordered = window_vals;
      for (int i = 1; i < stmf_pkg::WINDOW; i++) begin
        key = ordered[i];
        j   = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      total = 0;
      for (int i = stmf_pkg::TRIM; i < stmf_pkg::WINDOW - stmf_pkg::TRIM; i++)
        total += ordered[i];
      mean = total / stmf_pkg::HALF;
      if (mean > SMP_TOP) mean = SMP_TOP;
      expected_means.push_back(stmf_pkg::smp_t'(mean));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [15:0] word);
      stmf_pkg::smp_t want;
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("result %0d with no sample pending",
                                  word[stmf_pkg::SMP_W-1:0]));
      end else begin
        want = expected_means.pop_front();
        if (word[stmf_pkg::SMP_W-1:0] !== want)
          report_mismatch($sformatf("filtered got %0d, want %0d",
                                    word[stmf_pkg::SMP_W-1:0], want));
        if (word[15:stmf_pkg::SMP_W] !== '0)
          report_mismatch($sformatf("padding bits of result set: %h", word));
      end
    endtask

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  trimmed_mean_board means;
  int unsigned       samples_in;
  int unsigned       quiet_cycles = 0;

  sliding_trimmed_mean_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic stmf_pkg::smp_t random_sample(int unsigned center);
    int          v;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return stmf_pkg::smp_t'($urandom_range(0, SMP_TOP));
    if (mode < 7) begin
      v = int'(center) + $urandom_range(0, 64) - 32;
      if (v < 0) v = 0;
      if (v > SMP_TOP) v = SMP_TOP;
      return stmf_pkg::smp_t'(v);
    end
    if (mode == 7)
      return ($urandom_range(0, 1) != 0) ? stmf_pkg::smp_t'(SMP_TOP) : stmf_pkg::smp_t'(0);
    if (mode == 8) return stmf_pkg::smp_t'($urandom_range(0, 15));
    return stmf_pkg::smp_t'($urandom_range(SMP_TOP - 15, SMP_TOP));
  endfunction

  task automatic send_word(input logic [15:0] word, input int unsigned gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    means.note_sample(word[stmf_pkg::SMP_W-1:0]);
    samples_in++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) means.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("sliding_trimmed_mean_filter: mismatch");
    $finish;
  end

  // Receiver: random ready, one long hold-off to back up the block.
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && samples_in >= HOLD_OFF_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned center;
    bit          dense;
    means         = new();
    samples_in    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_word(DIRECTED[i], pick_gap());

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst  = $urandom_range(1, 40);
      dense  = ($urandom_range(0, 3) == 0);
      center = $urandom_range(0, SMP_TOP);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_word({4'b0000, random_sample(center)}, dense ? 0 : pick_gap());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (means.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (means.errors == 0 && means.pending() == 0) begin
      $display("sliding_trimmed_mean_filter: match");
    end else begin
      $display("sliding_trimmed_mean_filter: mismatch");
    end
    $finish;
  end

endmodule
